FILE: sv/pla_pkg.sv
// Shared types and constants of the paged linear allocator.
// Used by the interfaces, the register block, the allocation core and the top level.
`default_nettype none

package pla_pkg;

	// Default page pool depth
	localparam int unsigned MAX_PAGES_DEF = 16;

	// Field widths
	localparam int unsigned KIND_W   = 1;
	localparam int unsigned SIZE_W   = 24;
	localparam int unsigned ALIGN_W  = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PIDX_W   = 4;
	localparam int unsigned OFFS_W   = 25;

	// Arithmetic width of aligned values (align-up of a 31-bit mask)
	localparam int unsigned ARITH_W = 32;

	// Configuration port
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;
	localparam int unsigned PAGE_SIZE_W = 25;
	localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = PAGE_SIZE_W'(2097152);

	// Register indexes (word address)
	localparam logic [0:0] REG_PAGE_SIZE = 1'b0;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_RESET = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_NO_FIT    = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SIZE_W-1:0]  request_size;
		logic [ALIGN_W-1:0] alignment_log2;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [PIDX_W-1:0]  page_index;
		logic [OFFS_W-1:0]  byte_offset;
	} rsp_t;

	// Control from the pipeline to the allocation core
	typedef struct packed {
		logic fire;
		req_t item;
	} core_ctl_t;

endpackage

`default_nettype wire

FILE: sv/pla_ifs.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on pla_pkg for field widths.
`default_nettype none

interface pla_req_if;
	import pla_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SIZE_W-1:0]   request_size;
	logic [ALIGN_W-1:0]  alignment_log2;

	modport source (output valid, kind, request_size, alignment_log2, input ready);
	modport sink   (input valid, kind, request_size, alignment_log2, output ready);
endinterface

interface pla_rsp_if;
	import pla_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PIDX_W-1:0]   page_index;
	logic [OFFS_W-1:0]   byte_offset;

	modport source (output valid, status, page_index, byte_offset, input ready);
	modport sink   (input valid, status, page_index, byte_offset, output ready);
endinterface

`default_nettype wire

FILE: sv/pla_apb_regs.sv
// APB-style configuration register block holding page_size.
// Depends on pla_pkg.
`default_nettype none

module pla_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pla_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [pla_pkg::PDATA_W-1:0]    pwdata,
	output logic      [pla_pkg::PDATA_W-1:0]    prdata,
	output logic                               pready,
	output logic      [pla_pkg::PAGE_SIZE_W-1:0] page_size
);
	import pla_pkg::*;

	logic [PAGE_SIZE_W-1:0] page_size_q;
	logic                   wr_en;
	logic                   sel_page_size;

	// Decode by word address, byte lanes ignored
	assign sel_page_size = (paddr[2] == REG_PAGE_SIZE);
	assign wr_en         = psel && penable && pwrite && sel_page_size;
	assign pready        = 1'b1;

	// Hold the page size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RST;
		end else if (wr_en) begin
			page_size_q <= pwdata[PAGE_SIZE_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (sel_page_size) begin
			prdata = PDATA_W'(page_size_q);
		end
	end

	assign page_size = page_size_q;
endmodule

`default_nettype wire

FILE: sv/pla_alloc_core.sv
// Allocation core: page state registers and the single-pass align/fit decision.
// Depends on pla_pkg.
`default_nettype none

module pla_alloc_core #(
	parameter int unsigned MAX_PAGES = pla_pkg::MAX_PAGES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pla_pkg::core_ctl_t             ctl,
	input  wire logic [pla_pkg::PAGE_SIZE_W-1:0] page_size,
	output pla_pkg::rsp_t                       rsp
);
	import pla_pkg::*;

	localparam int unsigned PG_W = $clog2(MAX_PAGES + 1);
	localparam logic [PG_W-1:0] PG_MAX = PG_W'(MAX_PAGES);

	logic                has_cur_q;
	logic [PG_W-1:0]     cur_page_q;
	logic [PG_W-1:0]     next_page_q;
	logic [PG_W-1:0]     built_q;
	logic [OFFS_W-1:0]   fill_q;

	logic                has_cur_d;
	logic [PG_W-1:0]     cur_page_d;
	logic [PG_W-1:0]     next_page_d;
	logic [PG_W-1:0]     built_d;
	logic [OFFS_W-1:0]   fill_d;

	logic [ARITH_W-1:0]  mask;
	logic [ARITH_W-1:0]  asize;
	logic [ARITH_W-1:0]  aoff;
	logic [ARITH_W:0]    end_off;
	logic [ARITH_W-1:0]  new_fill;
	logic                too_large;
	logic                no_room;
	logic                reuse;
	logic                can_build;
	logic [PG_W-1:0]     pg;
	logic [ARITH_W-1:0]  pg_wide;

	// Align-up of size and fill offset
	assign mask      = (ARITH_W'(1) << ctl.item.alignment_log2) - ARITH_W'(1);
	assign asize     = (ARITH_W'(ctl.item.request_size) + mask) & ~mask;
	assign aoff      = (ARITH_W'(fill_q) + mask) & ~mask;
	assign end_off   = {1'b0, aoff} + {1'b0, asize};
	assign too_large = ({1'b0, ctl.item.request_size} > page_size);
	assign no_room   = (end_off > (ARITH_W + 1)'(page_size));
	assign reuse     = (next_page_q < built_q);
	assign can_build = (built_q < PG_MAX);
	assign pg        = reuse ? next_page_q : built_q;
	assign pg_wide   = ARITH_W'(pg);

	// Decide result and next state
	always_comb begin
		has_cur_d       = has_cur_q;
		cur_page_d      = cur_page_q;
		next_page_d     = next_page_q;
		built_d         = built_q;
		fill_d          = fill_q;
		new_fill        = '0;
		rsp.status      = ST_OK;
		rsp.page_index  = '0;
		rsp.byte_offset = '0;

		if (ctl.item.kind == KIND_RESET) begin
			has_cur_d   = 1'b0;
			next_page_d = '0;
			fill_d      = '0;
		end else if (too_large) begin
			rsp.status = ST_TOO_LARGE;
		end else if (!has_cur_q || no_room) begin
			if (!reuse && !can_build) begin
				rsp.status = ST_EXHAUSTED;
			end else begin
				if (!reuse) begin
					built_d = built_q + PG_W'(1);
				end
				next_page_d    = pg + PG_W'(1);
				cur_page_d     = pg;
				has_cur_d      = 1'b1;
				rsp.page_index = pg_wide[PIDX_W-1:0];
				if (asize > ARITH_W'(page_size)) begin
					rsp.status = ST_NO_FIT;
					fill_d     = '0;
				end else begin
					fill_d = asize[OFFS_W-1:0];
				end
			end
		end else begin
			new_fill        = end_off[ARITH_W-1:0];
			fill_d          = new_fill[OFFS_W-1:0];
			rsp.page_index  = PIDX_W'(ARITH_W'(cur_page_q));
			rsp.byte_offset = aoff[OFFS_W-1:0];
		end
	end

	// Advance page state on each transfer into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_cur_q   <= 1'b0;
			cur_page_q  <= '0;
			next_page_q <= '0;
			built_q     <= '0;
			fill_q      <= '0;
		end else if (ctl.fire) begin
			has_cur_q   <= has_cur_d;
			cur_page_q  <= cur_page_d;
			next_page_q <= next_page_d;
			built_q     <= built_d;
			fill_q      <= fill_d;
		end
	end
endmodule

`default_nettype wire

FILE: sv/paged_linear_allocator_top.sv
// Top level of the paged linear allocator: input register, allocation core, result register.
// Depends on pla_pkg, pla_ifs, pla_apb_regs and pla_alloc_core.
`default_nettype none

// Paged bump allocator. One request or frame-reset item is accepted per clock cycle as
// long as the result register is free or being drained: the item is captured in an input
// register, then the page state is updated and the answer is computed as the item moves
// on into a result register, where the answer sits until it is taken. The accept rate is
// set by the page state update, so back-to-back items see no bubbles as long as results
// are drained. Program page_size over the APB port only while no item is in flight; it
// resets to 2 MiB. MAX_PAGES sets the page pool depth (1 to 16).
module paged_linear_allocator_top #(
	parameter int unsigned MAX_PAGES = pla_pkg::MAX_PAGES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pla_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [pla_pkg::PDATA_W-1:0]  pwdata,
	output logic      [pla_pkg::PDATA_W-1:0]  prdata,
	output logic                             pready,
	pla_req_if.sink                          req,
	pla_rsp_if.source                        rsp
);
	import pla_pkg::*;

	logic                   valid_s1;
	req_t                   item_s1;
	logic                   out_valid_q;
	rsp_t                   rsp_q;
	rsp_t                   rsp_d;
	logic                   adv;
	logic                   take;
	core_ctl_t              ctl;
	logic [PAGE_SIZE_W-1:0] page_size;

	pla_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.page_size (page_size)
	);

	// Move input stage into result stage when the result slot is free or its result is being taken
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	assign ctl.fire = adv;
	assign ctl.item = item_s1;

	pla_alloc_core #(
		.MAX_PAGES (MAX_PAGES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.page_size (page_size),
		.rsp       (rsp_d)
	);

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind           <= req.kind;
			item_s1.request_size   <= req.request_size;
			item_s1.alignment_log2 <= req.alignment_log2;
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.page_index  = rsp_q.page_index;
	assign rsp.byte_offset = rsp_q.byte_offset;
endmodule

`default_nettype wire

FILE: sv/pla_checker.sv
// Port-level checks on the result channel of the paged linear allocator.
// Depends on pla_pkg; bound to paged_linear_allocator_top.
`default_nettype none

module pla_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [pla_pkg::STATUS_W-1:0]   rsp_status,
	input wire logic [pla_pkg::PIDX_W-1:0]     rsp_page_index,
	input wire logic [pla_pkg::OFFS_W-1:0]     rsp_byte_offset
);
	import pla_pkg::*;

	// A pending result stays offered until taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	// A pending result keeps its payload until taken
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_page_index)
			&& $stable(rsp_byte_offset))
		else $error("result payload changed while stalled");

	// Rejected requests carry no page and no offset
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_TOO_LARGE || rsp_status == ST_EXHAUSTED)
			|-> rsp_page_index == '0 && rsp_byte_offset == '0)
		else $error("rejected request reports a location");

	// An oversized aligned request lands at the start of its fresh page
	a_nofit_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_NO_FIT |-> rsp_byte_offset == '0)
		else $error("no-fit result with nonzero offset");
endmodule

bind paged_linear_allocator_top pla_checker u_pla_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_page_index  (rsp.page_index),
	.rsp_byte_offset (rsp.byte_offset)
);

`default_nettype wire
